// ===== rtl/core/spmb_pkg.sv =====
// Shared types, constants and helpers for the scroll-position marker box block.
`timescale 1ns / 1ps
package spmb_pkg;

  localparam int unsigned PosW     = 17;  // signed input position
  localparam int unsigned CoordW   = 12;  // config coordinate / size
  localparam int unsigned RngW     = 16;  // range_last
  localparam int unsigned OutXyW   = 13;  // output box_x / box_y
  localparam int unsigned OutWhW   = 12;  // output box_w / box_h
  localparam int unsigned QuoW     = 13;  // quotient bits of a mapped position
  localparam int unsigned ProdW    = RngW + QuoW;  // dividend magnitude
  localparam int unsigned NStep    = QuoW;         // divider stages
  localparam int unsigned NLane    = 4;            // parallel position mappers
  localparam int unsigned LaneW    = 2;            // lane index width
  localparam int unsigned MathW    = 18;           // signed box arithmetic
  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 56;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned NBox     = 3;

  // lane roles
  localparam logic [LaneW-1:0] LaneStart    = 2'd0;  // start, full length
  localparam logic [LaneW-1:0] LaneEnd      = 2'd1;  // end, full length
  localparam logic [LaneW-1:0] LaneSingle   = 2'd2;  // start, length - min_mark
  localparam logic [LaneW-1:0] LaneMidpoint = 2'd3;  // midpoint, length - min_mark

  typedef enum logic [CfgAddrW-1:0] {
    CfgIndX      = 3'd0,
    CfgIndY      = 3'd1,
    CfgIndWidth  = 3'd2,
    CfgIndHeight = 3'd3,
    CfgMinMark   = 3'd4,
    CfgRangeLast = 3'd5,
    CfgBackgrnd  = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MapZero = 2'd0,
    MapFull = 2'd1,
    MapDiv  = 2'd2
  } map_kind_e;

  typedef struct packed {
    logic [CoordW-1:0] ind_x;
    logic [CoordW-1:0] ind_y;
    logic [CoordW-1:0] ind_width;
    logic [CoordW-1:0] ind_height;
    logic [CoordW-1:0] min_mark;
    logic [RngW-1:0]   range_last;
    logic              background;
  } cfg_t;

  typedef struct packed {
    logic [ProdW-1:0] rem;
    logic [QuoW-1:0]  quo;
    logic             neg;
    map_kind_e        kind;
  } lane_t;

  typedef struct packed {
    logic signed [MathW-1:0] sp;
    logic signed [MathW-1:0] ep;
    logic signed [MathW-1:0] mpos;
    logic signed [MathW-1:0] mlen;
    logic signed [MathW-1:0] lenv;
    logic                    vert;
  } res_t;

  typedef struct packed {
    logic [OutXyW-1:0] x;
    logic [OutXyW-1:0] y;
    logic [OutWhW-1:0] w;
    logic [OutWhW-1:0] h;
    logic              on;
  } box_t;

  function automatic logic signed [MathW-1:0] ext12(input logic [CoordW-1:0] v);
    return $signed({{(MathW-CoordW){1'b0}}, v});
  endfunction

endpackage

// ===== rtl/core/spmb_prep.sv =====
// Input stage: position decode, midpoint and dividend products for four mappers.
`timescale 1ns / 1ps
module spmb_prep import spmb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [PosW-1:0]   start_pos_i,
  input  logic [PosW-1:0]   end_pos_i,
  input  cfg_t              cfg_i,
  output logic              valid_o,
  output logic              gt_o,
  output lane_t             lanes_o [NLane]
);

  logic signed [PosW-1:0]  start_s, end_s, mid_s;
  logic signed [PosW:0]    sum_s;
  logic                    vert;
  logic signed [QuoW:0]    len_s, len2_s;
  logic                    valid_q, gt_q;
  lane_t                   lanes_d [NLane];
  lane_t                   lanes_q [NLane];

  function automatic lane_t make_lane(input logic signed [PosW-1:0] p,
                                      input logic signed [QuoW:0]   l,
                                      input logic [RngW-1:0]        rng);
    lane_t                r;
    logic signed [QuoW+1:0] lm2;
    logic [QuoW-1:0]      mag;
    lm2 = {l[QuoW], l} - 15'sd2;
    r.neg = lm2[QuoW+1];
    mag = r.neg ? QuoW'(-lm2) : lm2[QuoW-1:0];
    r.rem = ProdW'(p[RngW-1:0]) * ProdW'(mag);
    r.quo = '0;
    if (p <= 0) begin
      r.kind = MapZero;
    end else if (p[RngW-1:0] >= rng) begin
      r.kind = MapFull;
    end else begin
      r.kind = MapDiv;
    end
    return r;
  endfunction

  always_comb begin
    start_s = $signed(start_pos_i);
    end_s   = $signed(end_pos_i);
    sum_s   = {start_s[PosW-1], start_s} + {end_s[PosW-1], end_s};
    // halve toward zero
    mid_s   = PosW'((sum_s + {{PosW{1'b0}}, sum_s[PosW]}) >>> 1);
    vert    = cfg_i.ind_height >= cfg_i.ind_width;
    len_s   = $signed({2'b00, vert ? cfg_i.ind_height : cfg_i.ind_width});
    len2_s  = len_s - $signed({2'b00, cfg_i.min_mark});
    lanes_d[LaneStart]    = make_lane(start_s, len_s,  cfg_i.range_last);
    lanes_d[LaneEnd]      = make_lane(end_s,   len_s,  cfg_i.range_last);
    lanes_d[LaneSingle]   = make_lane(start_s, len2_s, cfg_i.range_last);
    lanes_d[LaneMidpoint] = make_lane(mid_s,   len2_s, cfg_i.range_last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      gt_q    <= end_s > start_s;
      lanes_q <= lanes_d;
    end
  end

  assign valid_o = valid_q;
  assign gt_o    = gt_q;
  assign lanes_o = lanes_q;

endmodule

// ===== rtl/core/spmb_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, four lanes.
`timescale 1ns / 1ps
module spmb_div import spmb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [RngW-1:0]   range_last_i,
  input  logic              valid_i,
  input  logic              gt_i,
  input  lane_t             lanes_i [NLane],
  output logic              valid_o,
  output logic              gt_o,
  output lane_t             lanes_o [NLane]
);

  logic  valid_q [NStep];
  logic  gt_q    [NStep];
  lane_t st_q    [NStep][NLane];

  for (genvar s = 0; s < NStep; s++) begin : g_stage
    localparam int unsigned Bit = NStep - 1 - s;
    logic  src_valid, src_gt;
    lane_t src  [NLane];
    lane_t nxt  [NLane];

    if (s == 0) begin : g_first
      assign src_valid = valid_i;
      assign src_gt    = gt_i;
      assign src       = lanes_i;
    end else begin : g_next
      assign src_valid = valid_q[s-1];
      assign src_gt    = gt_q[s-1];
      assign src       = st_q[s-1];
    end

    always_comb begin
      logic [ProdW:0] trial;
      for (int l = 0; l < NLane; l++) begin
        nxt[l] = src[l];
        trial  = {1'b0, src[l].rem} - ((ProdW+1)'(range_last_i) << Bit);
        if (!trial[ProdW]) begin
          nxt[l].rem      = trial[ProdW-1:0];
          nxt[l].quo[Bit] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        valid_q[s] <= 1'b0;
      end else if (en_i) begin
        valid_q[s] <= src_valid;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        gt_q[s] <= src_gt;
        st_q[s] <= nxt;
      end
    end
  end

  assign valid_o = valid_q[NStep-1];
  assign gt_o    = gt_q[NStep-1];
  assign lanes_o = st_q[NStep-1];

endmodule

// ===== rtl/core/spmb_resolve.sv =====
// Picks marker offset, end and length from the mapped positions.
`timescale 1ns / 1ps
module spmb_resolve import spmb_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   en_i,
  input  cfg_t   cfg_i,
  input  logic   valid_i,
  input  logic   gt_i,
  input  lane_t  lanes_i [NLane],
  output logic   valid_o,
  output res_t   res_o
);

  logic signed [MathW-1:0] len, len2, minm, along0;
  logic signed [MathW-1:0] va, vb, vc, vd;
  logic                    vert, single, use_mid;
  res_t                    res_d, res_q;
  logic                    valid_q;

  function automatic logic signed [MathW-1:0] map_value(input lane_t ln,
                                                       input logic signed [MathW-1:0] l);
    logic signed [MathW-1:0] q;
    q = $signed({{(MathW-QuoW){1'b0}}, ln.quo});
    case (ln.kind)
      MapZero: return '0;
      MapFull: return l;
      MapDiv:  return ln.neg ? 18'sd1 - q : q + 18'sd1;
      default: return '0;
    endcase
  endfunction

  always_comb begin
    vert   = cfg_i.ind_height >= cfg_i.ind_width;
    len    = ext12(vert ? cfg_i.ind_height : cfg_i.ind_width);
    along0 = ext12(vert ? cfg_i.ind_y : cfg_i.ind_x);
    minm   = ext12(cfg_i.min_mark);
    len2   = len - minm;
    va = map_value(lanes_i[LaneStart], len);
    vb = map_value(lanes_i[LaneEnd], len);
    vc = map_value(lanes_i[LaneSingle], len2);
    vd = map_value(lanes_i[LaneMidpoint], len2);

    res_d.vert = vert;
    res_d.sp   = va;
    res_d.ep   = vb;
    res_d.mpos = along0;
    res_d.mlen = '0;
    res_d.lenv = len;
    single     = !gt_i;
    use_mid    = 1'b0;
    if (gt_i && (vb - va < minm)) begin
      if (va == 0) begin
        res_d.ep = minm;
      end else if (vb == len) begin
        res_d.sp = vb - minm;
      end else begin
        single  = 1'b1;
        use_mid = 1'b1;
      end
    end
    if (!single && res_d.ep != 0) begin
      res_d.mpos = along0 + res_d.sp;
      res_d.mlen = res_d.ep - res_d.sp;
    end
    if (single) begin
      res_d.lenv = len2;
      res_d.sp   = use_mid ? vd : vc;
      res_d.mpos = along0 + res_d.sp;
      res_d.mlen = minm;
      res_d.ep   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== rtl/core/spmb_out.sv =====
// Builds the rectangles and sends them out one beat each; owns the stall.
`timescale 1ns / 1ps
module spmb_out import spmb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  logic                valid_i,
  input  res_t                res_i,
  output logic                en_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,
  output logic                m_axis_tlast
);

  box_t             box_d  [NBox];
  box_t             box_q  [NBox];
  logic [NBox-1:0]  mask_d, mask_q, sel, rest;
  logic [1:0]       idx;
  box_t             cur;
  logic             ok0, ok1, ok2;
  logic signed [MathW-1:0] x, y, w, h, cross_len, across0;

  function automatic box_t mk_box(input logic signed [MathW-1:0] bx,
                                  input logic signed [MathW-1:0] by,
                                  input logic signed [MathW-1:0] bw,
                                  input logic signed [MathW-1:0] bh,
                                  input logic on);
    box_t b;
    b.x  = bx[OutXyW-1:0];
    b.y  = by[OutXyW-1:0];
    b.w  = (bw > 18'sd4095) ? '1 : bw[OutWhW-1:0];
    b.h  = (bh > 18'sd4095) ? '1 : bh[OutWhW-1:0];
    b.on = on;
    return b;
  endfunction

  always_comb begin
    x         = ext12(cfg_i.ind_x);
    y         = ext12(cfg_i.ind_y);
    w         = ext12(cfg_i.ind_width);
    h         = ext12(cfg_i.ind_height);
    cross_len = res_i.vert ? w : h;
    across0   = res_i.vert ? x : y;
    if (!res_i.vert) begin
      box_d[0] = mk_box(x, y, w, h, cfg_i.background);
      ok0      = (w > 0) && (h > 0);
      box_d[1] = mk_box(res_i.mpos, across0, res_i.mlen, cross_len, !cfg_i.background);
      ok1      = (res_i.mlen > 0) && (cross_len > 0);
      box_d[2] = box_d[1];
      ok2      = 1'b0;
    end else begin
      box_d[0] = mk_box(x, y, w, res_i.sp - 18'sd1, cfg_i.background);
      ok0      = (res_i.sp != 0) && (w > 0) && (res_i.sp - 18'sd1 > 0);
      box_d[1] = mk_box(across0, res_i.mpos, cross_len, res_i.mlen, !cfg_i.background);
      ok1      = (cross_len > 0) && (res_i.mlen > 0);
      box_d[2] = mk_box(across0, res_i.mpos + res_i.mlen + 18'sd1, w,
                        h - res_i.mlen - res_i.sp - 18'sd1, cfg_i.background);
      ok2      = (res_i.ep != res_i.lenv) && (w > 0) &&
                 (h - res_i.mlen - res_i.sp - 18'sd1 > 0);
    end
    mask_d = valid_i ? {ok2, ok1, ok0} : '0;
  end

  // lowest pending rectangle goes first
  always_comb begin
    if (mask_q[0]) begin
      idx = 2'd0;
    end else if (mask_q[1]) begin
      idx = 2'd1;
    end else begin
      idx = 2'd2;
    end
    sel  = NBox'(1) << idx;
    rest = mask_q & ~sel;
    cur  = box_q[idx];
  end

  assign m_axis_tvalid = |mask_q;
  assign m_axis_tlast  = rest == '0;
  assign m_axis_tdata  = {{(OutDataW-$bits(box_t)){1'b0}},
                          cur.on, cur.h, cur.w, cur.y, cur.x};
  assign en_o          = !m_axis_tvalid || (m_axis_tready && m_axis_tlast);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
    end else if (en_o) begin
      mask_q <= mask_d;
    end else if (m_axis_tready) begin
      mask_q <= rest;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_o) begin
      box_q <= box_d;
    end
  end

endmodule

// ===== rtl/core/scroll_position_marker_boxes.sv =====
// Top level of the scroll-position marker box generator.
`timescale 1ns / 1ps
//
//  channel   dir  handshake                 payload
//  s_axis    in   s_axis_tvalid/tready      tdata: start_pos, end_pos
//  m_axis    out  m_axis_tvalid/tready      tdata: box_x..pixel_on, tlast: last
//  cfg       in   cfg_valid_i/cfg_ready_o   cfg_addr_i (register), cfg_data_i
//
//  An item runs 16 register stages: input decode with the four dividend
//  products, 13 divider stages (one quotient bit each), resolve, and the box
//  builder feeding the output register. One item can enter per cycle while
//  the output is empty or its last beat is being taken; the output sends up
//  to 3 beats per item, one per rectangle. Items with no rectangle leave
//  nothing behind. The whole pipeline advances together; a stalled output
//  holds every stage. Reset clears all valid bits and loads register defaults.
//  Config writes are always taken; the cfg port never stalls.
module scroll_position_marker_boxes import spmb_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // config write
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgAddrW-1:0] cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  // input beats
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,   // [16:0] start_pos, [33:17] end_pos
  // output beats
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,   // [12:0] box_x, [25:13] box_y,
                                              // [37:26] box_w, [49:38] box_h,
                                              // [50] pixel_on
  output logic                m_axis_tlast    // last
);

  cfg_t  cfg_q;
  logic  en;
  logic  prep_valid, prep_gt, div_valid, div_gt, res_valid;
  lane_t prep_lanes [NLane];
  lane_t div_lanes  [NLane];
  res_t  res;

  assign cfg_ready_o = 1'b1;

  // register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ind_x      <= 12'd0;
      cfg_q.ind_y      <= 12'd0;
      cfg_q.ind_width  <= 12'd1;
      cfg_q.ind_height <= 12'd3;
      cfg_q.min_mark   <= 12'd1;
      cfg_q.range_last <= 16'd0;
      cfg_q.background <= 1'b0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CfgIndX:      cfg_q.ind_x      <= cfg_data_i[CoordW-1:0];
        CfgIndY:      cfg_q.ind_y      <= cfg_data_i[CoordW-1:0];
        CfgIndWidth:  cfg_q.ind_width  <= cfg_data_i[CoordW-1:0];
        CfgIndHeight: cfg_q.ind_height <= cfg_data_i[CoordW-1:0];
        CfgMinMark:   cfg_q.min_mark   <= cfg_data_i[CoordW-1:0];
        CfgRangeLast: cfg_q.range_last <= cfg_data_i[RngW-1:0];
        CfgBackgrnd:  cfg_q.background <= cfg_data_i[0];
        default:      ;
      endcase
    end
  end

  assign s_axis_tready = en;

  spmb_prep u_prep (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (s_axis_tvalid),
    .start_pos_i (s_axis_tdata[PosW-1:0]),
    .end_pos_i   (s_axis_tdata[2*PosW-1:PosW]),
    .cfg_i       (cfg_q),
    .valid_o     (prep_valid),
    .gt_o        (prep_gt),
    .lanes_o     (prep_lanes)
  );

  spmb_div u_div (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .range_last_i (cfg_q.range_last),
    .valid_i      (prep_valid),
    .gt_i         (prep_gt),
    .lanes_i      (prep_lanes),
    .valid_o      (div_valid),
    .gt_o         (div_gt),
    .lanes_o      (div_lanes)
  );

  spmb_resolve u_resolve (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .cfg_i   (cfg_q),
    .valid_i (div_valid),
    .gt_i    (div_gt),
    .lanes_i (div_lanes),
    .valid_o (res_valid),
    .res_o   (res)
  );

  spmb_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .valid_i       (res_valid),
    .res_i         (res),
    .en_o          (en),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== rtl/core/spmb_checker.sv =====
// Port-level checks for the marker box generator, bound to the top level.
`timescale 1ns / 1ps
module spmb_checker import spmb_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready
);

  // output beat is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output beat dropped while stalled");

  // nothing pending on the output once a reset edge has passed
  a_reset_idle: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("output valid during reset");

  // an empty output register never blocks input
  a_ready_when_empty: assert property (@(posedge clk_i)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  // a stalled output freezes the pipeline
  a_stall_blocks: assert property (@(posedge clk_i)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output stalled");

endmodule

bind scroll_position_marker_boxes spmb_checker u_spmb_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
